### sv/assert_macros.svh
// concurrent assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold at every rising clock edge out of reset
`define ASSERT_SYNC(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// implication checked at every rising clock edge out of reset
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_SYNC(lbl, clk, rstn, prop)
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)

`endif

`endif

### sv/lppm_pkg.sv
`default_nettype none

package lppm_pkg;

  // fixed field widths
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned IN_CHAR_W = 21;
  localparam int unsigned IDX_W     = 5;
  localparam int unsigned CONS_W    = 5;
  localparam int unsigned STAT_W    = 2;

  // op codes carried in in_tuser
  localparam logic OP_MATCH = 1'b0;
  localparam logic OP_REG   = 1'b1;

  // result kinds carried in out_tuser
  localparam logic KIND_MATCH = 1'b0;
  localparam logic KIND_REG   = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_INVALID  = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STAT_W-1:0] ST_NO_MATCH = 2'd3;

  // broadcast match command shared by every cell
  typedef struct packed {
    logic              match_fire;
    logic              pos_zero;
    logic              char_ok;
    logic [CHAR_W-1:0] char_byte;
  } cell_cmd_t;

  // per-cell write strobes from the registration sequencer
  typedef struct packed {
    logic first;
    logic suffix;
    logic commit;
  } cell_wr_t;

  // handed from cell to cell, high index toward low index
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
    logic             any_alive;
  } chain_t;

endpackage

`default_nettype wire

### sv/longest_prefix_pattern_matcher_top.sv
`default_nettype none

// Longest-prefix pattern matcher. Patterns of 8-bit characters are registered
// with op = 1 items ending in char 0; each gets the next bit index and one
// registration result (ok, invalid, or table full). Match strings are streamed
// with op = 0 items; one result follows as soon as no stored pattern can still
// extend, naming the longest completed pattern (newest on a tie) and the
// characters consumed. Each entry lives in its own cell of a row that compares
// every character in parallel, so the block takes one item per clock cycle and
// delivers a result in the output register in the cycle after the item that causes
// it; input is held off only while that register is full and not taken.
module longest_prefix_pattern_matcher_top #(
  parameter int unsigned MAX_ENTRIES = 32,
  parameter int unsigned MAX_LEN     = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [20:0] char_code, [23:21] zero
  input  wire logic        in_tuser,   // [0] op
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [1:0] status, [6:2] bit_index,
                                       // [11:7] consumed, [15:12] zero
  output logic             out_tuser   // [0] kind
);

  localparam int unsigned LW  = $clog2(MAX_LEN);
  localparam int unsigned AW  = (MAX_LEN > 2) ? $clog2(MAX_LEN - 1) : 1;
  localparam int unsigned BLW = $clog2(MAX_LEN + 1);
  localparam int unsigned RLW = $clog2(MAX_LEN + 2);
  localparam int unsigned CW  = $clog2(MAX_ENTRIES + 1);

  // sequencer state
  logic [CW-1:0]                 entry_count_r, entry_count_nxt;
  logic [LW-1:0]                 match_pos_r, match_pos_nxt;
  logic [BLW-1:0]                top_len_r, top_len_nxt;
  logic [lppm_pkg::IDX_W-1:0]    best_entry_r, best_entry_nxt;
  logic [RLW-1:0]                reg_len_r, reg_len_nxt;
  logic                          reg_bad_r, reg_bad_nxt;

  // output register
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_kind_r, out_kind_nxt;
  logic [lppm_pkg::STAT_W-1:0]   out_status_r, out_status_nxt;
  logic [lppm_pkg::IDX_W-1:0]    out_bit_r, out_bit_nxt;
  logic [lppm_pkg::CONS_W-1:0]   out_cons_r, out_cons_nxt;

  logic                          in_fire;
  logic                          match_fire;
  logic                          reg_fire;
  logic [lppm_pkg::IN_CHAR_W-1:0] char_code;
  logic [lppm_pkg::CHAR_W-1:0]   char_byte;
  logic                          char_zero;
  logic                          char_wide;
  logic                          slot_ok;
  logic [BLW-1:0]                cand_len;
  logic [lppm_pkg::IDX_W-1:0]    cand_entry;
  logic [AW-1:0]                 wr_addr;
  logic [AW-1:0]                 rd_addr_nxt;
  logic [LW-1:0]                 commit_len;
  logic                          wr_first_en;
  logic                          wr_suffix_en;
  logic                          commit_en;

  lppm_pkg::cell_cmd_t           cmd;
  lppm_pkg::cell_wr_t            cell_wr [MAX_ENTRIES];
  lppm_pkg::chain_t              chain [MAX_ENTRIES+1];
  logic [MAX_ENTRIES-1:0]        alive_vec;

  // input decode
  assign in_tready  = !out_valid_r || out_tready;
  assign in_fire    = in_tvalid && in_tready;
  assign match_fire = in_fire && (in_tuser == lppm_pkg::OP_MATCH);
  assign reg_fire   = in_fire && (in_tuser == lppm_pkg::OP_REG);
  assign char_code  = in_tdata[lppm_pkg::IN_CHAR_W-1:0];
  assign char_byte  = char_code[lppm_pkg::CHAR_W-1:0];
  assign char_zero  = (char_code == '0);
  assign char_wide  = (char_code[lppm_pkg::IN_CHAR_W-1:lppm_pkg::CHAR_W] != '0);
  assign slot_ok    = (entry_count_r < CW'(MAX_ENTRIES));

  // broadcast command to the cell row
  always_comb begin
    cmd.match_fire = match_fire;
    cmd.pos_zero   = (match_pos_r == '0);
    cmd.char_ok    = !char_zero && !char_wide;
    cmd.char_byte  = char_byte;
  end

  // registration write strobes
  assign wr_first_en  = reg_fire && !char_zero && slot_ok && (reg_len_r == '0);
  assign wr_suffix_en = reg_fire && !char_zero && slot_ok && (reg_len_r != '0) &&
                        (reg_len_r < RLW'(MAX_LEN));
  assign commit_en    = reg_fire && char_zero && slot_ok && !reg_bad_r &&
                        (reg_len_r != '0) && (reg_len_r <= RLW'(MAX_LEN));
  assign wr_addr      = AW'(reg_len_r - RLW'(1));
  assign commit_len   = LW'(reg_len_r - RLW'(1));

  // completion candidate from the chain
  always_comb begin
    cand_len   = top_len_r;
    cand_entry = best_entry_r;
    if (chain[0].found) begin
      cand_len   = BLW'(match_pos_r) + BLW'(1);
      cand_entry = chain[0].idx;
    end
  end

  // next-state logic for both sequencers and the output register
  always_comb begin
    entry_count_nxt = entry_count_r;
    match_pos_nxt   = match_pos_r;
    top_len_nxt     = top_len_r;
    best_entry_nxt  = best_entry_r;
    reg_len_nxt     = reg_len_r;
    reg_bad_nxt     = reg_bad_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_kind_nxt    = out_kind_r;
    out_status_nxt  = out_status_r;
    out_bit_nxt     = out_bit_r;
    out_cons_nxt    = out_cons_r;

    // match sequencer
    if (match_fire) begin
      if (!chain[0].any_alive) begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = lppm_pkg::KIND_MATCH;
        if (cand_len != '0) begin
          out_status_nxt = lppm_pkg::ST_OK;
          out_bit_nxt    = cand_entry;
          out_cons_nxt   = lppm_pkg::CONS_W'(cand_len);
        end else begin
          out_status_nxt = lppm_pkg::ST_NO_MATCH;
          out_bit_nxt    = '0;
          out_cons_nxt   = '0;
        end
        match_pos_nxt  = '0;
        top_len_nxt    = '0;
        best_entry_nxt = '0;
      end else begin
        match_pos_nxt  = match_pos_r + LW'(1);
        top_len_nxt    = cand_len;
        best_entry_nxt = cand_entry;
      end
    end

    // registration sequencer
    if (reg_fire) begin
      if (!char_zero) begin
        if (char_wide) begin
          reg_bad_nxt = 1'b1;
        end
        if (reg_len_r <= RLW'(MAX_LEN)) begin
          reg_len_nxt = reg_len_r + RLW'(1);
        end
      end else begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = lppm_pkg::KIND_REG;
        out_bit_nxt   = '0;
        out_cons_nxt  = '0;
        if (reg_len_r == '0 || reg_len_r > RLW'(MAX_LEN) || reg_bad_r) begin
          out_status_nxt = lppm_pkg::ST_INVALID;
        end else if (!slot_ok) begin
          out_status_nxt = lppm_pkg::ST_FULL;
        end else begin
          out_status_nxt  = lppm_pkg::ST_OK;
          out_bit_nxt     = lppm_pkg::IDX_W'(entry_count_r);
          entry_count_nxt = entry_count_r + CW'(1);
        end
        reg_len_nxt = '0;
        reg_bad_nxt = 1'b0;
      end
    end
  end

  // prefetch address for the suffix memories
  assign rd_addr_nxt = (match_pos_nxt == '0) ? '0 : AW'(match_pos_nxt - LW'(1));

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
      match_pos_r   <= '0;
      top_len_r     <= '0;
      best_entry_r  <= '0;
      reg_len_r     <= '0;
      reg_bad_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      entry_count_r <= entry_count_nxt;
      match_pos_r   <= match_pos_nxt;
      top_len_r     <= top_len_nxt;
      best_entry_r  <= best_entry_nxt;
      reg_len_r     <= reg_len_nxt;
      reg_bad_r     <= reg_bad_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_kind_r   <= out_kind_nxt;
    out_status_r <= out_status_nxt;
    out_bit_r    <= out_bit_nxt;
    out_cons_r   <= out_cons_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {4'd0, out_cons_r, out_bit_r, out_status_r};

  // row of entry cells, chain runs from the highest index down to zero
  assign chain[MAX_ENTRIES] = '0;

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    logic sel;

    assign sel = (entry_count_r == CW'(g));
    assign cell_wr[g].first  = wr_first_en && sel;
    assign cell_wr[g].suffix = wr_suffix_en && sel;
    assign cell_wr[g].commit = commit_en && sel;

    lppm_cell #(
      .MAX_LEN (MAX_LEN),
      .IDX     (g)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .cmd_i         (cmd),
      .wr_i          (cell_wr[g]),
      .wr_addr_i     (wr_addr),
      .rd_addr_nxt_i (rd_addr_nxt),
      .match_pos_i   (match_pos_r),
      .commit_len_i  (commit_len),
      .wr_char_i     (char_byte),
      .chain_i       (chain[g+1]),
      .chain_o       (chain[g]),
      .alive_o       (alive_vec[g])
    );
  end

  // checks
  `include "assert_macros.svh"

  `ASSERT_SYNC(a_count_bound, clk, rst_n, entry_count_r <= CW'(MAX_ENTRIES))
  `ASSERT_SYNC(a_reg_len_bound, clk, rst_n, reg_len_r <= RLW'(MAX_LEN + 1))
  `ASSERT_SYNC(a_pos_alive, clk, rst_n, (match_pos_r == '0) == (alive_vec == '0))
  `ASSERT_IMPL(a_reg_result, clk, rst_n, reg_fire && char_zero, ##1 out_valid_r && out_kind_r == lppm_pkg::KIND_REG)

endmodule

`default_nettype wire

### sv/lppm_cell.sv
`default_nettype none

module lppm_cell #(
  parameter int unsigned MAX_LEN = 16,
  parameter int unsigned IDX     = 0
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire lppm_pkg::cell_cmd_t   cmd_i,
  input  wire lppm_pkg::cell_wr_t    wr_i,
  input  wire logic [(MAX_LEN > 2 ? $clog2(MAX_LEN-1) : 1)-1:0] wr_addr_i,
  input  wire logic [(MAX_LEN > 2 ? $clog2(MAX_LEN-1) : 1)-1:0] rd_addr_nxt_i,
  input  wire logic [$clog2(MAX_LEN)-1:0] match_pos_i,
  input  wire logic [$clog2(MAX_LEN)-1:0] commit_len_i,
  input  wire logic [lppm_pkg::CHAR_W-1:0] wr_char_i,
  input  wire lppm_pkg::chain_t      chain_i,
  output lppm_pkg::chain_t           chain_o,
  output logic                       alive_o
);

  localparam int unsigned LW = $clog2(MAX_LEN);
  localparam int unsigned SD = MAX_LEN - 1;

  logic                          valid_r;
  logic                          alive_r;
  logic [lppm_pkg::CHAR_W-1:0]   first_r;
  logic [LW-1:0]                 len_r;
  logic [lppm_pkg::CHAR_W-1:0]   suffix_mem [SD];
  logic [lppm_pkg::CHAR_W-1:0]   rd_r;

  logic                          cand;
  logic [lppm_pkg::CHAR_W-1:0]   cmp_char;
  logic                          hit;
  logic                          done;
  logic                          alive_nxt;

  // compare the incoming character against this entry
  always_comb begin
    cand      = cmd_i.pos_zero ? valid_r : alive_r;
    cmp_char  = cmd_i.pos_zero ? first_r : rd_r;
    hit       = cand && cmd_i.char_ok && (cmp_char == cmd_i.char_byte);
    done      = hit && (len_r == match_pos_i);
    alive_nxt = hit && !done;
  end

  // pass the best completion and the live flag down the chain, higher index wins
  always_comb begin
    chain_o.found     = chain_i.found | done;
    chain_o.idx       = chain_i.found ? chain_i.idx : lppm_pkg::IDX_W'(IDX);
    chain_o.any_alive = chain_i.any_alive | alive_nxt;
  end

  assign alive_o = alive_r;

  // control bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      alive_r <= 1'b0;
    end else begin
      if (wr_i.commit) begin
        valid_r <= 1'b1;
      end
      if (cmd_i.match_fire) begin
        alive_r <= alive_nxt;
      end
    end
  end

  // pattern storage
  always_ff @(posedge clk) begin
    if (wr_i.first) begin
      first_r <= wr_char_i;
    end
    if (wr_i.commit) begin
      len_r <= commit_len_i;
    end
  end

  // suffix memory, read one character ahead of the next compare
  always_ff @(posedge clk) begin
    if (wr_i.suffix) begin
      suffix_mem[wr_addr_i] <= wr_char_i;
    end
    rd_r <= suffix_mem[rd_addr_nxt_i];
  end

endmodule

`default_nettype wire
